[hdl/ray_box_hit_point_assert.svh]
`ifndef RAY_BOX_HIT_POINT_ASSERT_SVH
`define RAY_BOX_HIT_POINT_ASSERT_SVH
// implication checked every clock edge outside reset
`define RBHP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbhp check failed");
// implication checked in the cycle after the antecedent
`define RBHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbhp check failed");
`endif

[hdl/rbhp_pkg.sv]
package rbhp_pkg;
   localparam int CoordBits = 32;
   localparam int FracBits  = 16;
   localparam int NumBits   = CoordBits + 1 + FracBits;
   localparam int DivSteps  = NumBits;
   localparam int DivStagesPerReg = 4;
   localparam int DivRegs   = (DivSteps + DivStagesPerReg - 1) / DivStagesPerReg;
   localparam int Latency   = DivRegs + 5;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic [NumBits-1:0]          mag_type;
   typedef logic [CoordBits-1:0]        dmag_type;

   localparam logic signed [CoordBits-1:0] MinusOne = -(CoordBits'(1) << FracBits);

   typedef struct packed {
      logic      valid;
      logic      in_box;
      coord_type org_x, org_y, org_z;
      coord_type dir_x, dir_y, dir_z;
      coord_type lo_x, lo_y, lo_z;
      coord_type hi_x, hi_y, hi_z;
      coord_type pl_x, pl_y, pl_z;
      logic [2:0] use_t;
   } ray_type;

   // saturate a magnitude to a signed word
   function automatic coord_type sat_word(input logic neg, input mag_type mag);
      logic [NumBits-1:0] lim;
      lim = NumBits'(1) << (CoordBits - 1);
      if (neg) begin
         if (mag >= lim) sat_word = coord_type'(lim);
         else sat_word = coord_type'(-mag);
      end else begin
         if (mag >= lim) sat_word = coord_type'(lim - 1);
         else sat_word = coord_type'(mag);
      end
   endfunction
endpackage

[hdl/rbhp_div.sv]
// pipelined restoring divider, magnitudes, several quotient bits per stage
module rbhp_div
   import rbhp_pkg::*;
(
   input  logic    clock,
   input  mag_type num_in,
   input  dmag_type den_in,
   output mag_type quo
);
   mag_type  n_ff [DivRegs+1];
   mag_type  q_ff [DivRegs+1];
   logic [CoordBits:0] r_ff [DivRegs+1];
   dmag_type d_ff [DivRegs+1];

   always_comb begin
      n_ff[0] = num_in;
      q_ff[0] = '0;
      r_ff[0] = '0;
      d_ff[0] = den_in;
   end

   for (genvar s = 0; s < DivRegs; s++) begin : g_st
      mag_type  n_in, q_in;
      logic [CoordBits:0] r_in;
      always_comb begin
         n_in = n_ff[s];
         q_in = q_ff[s];
         r_in = r_ff[s];
         for (int k = 0; k < DivStagesPerReg; k++) begin
            if (s * DivStagesPerReg + k < DivSteps) begin
               r_in = {r_in[CoordBits-1:0], n_in[NumBits-1]};
               n_in = n_in << 1;
               q_in = q_in << 1;
               if (r_in >= {1'b0, d_ff[s]}) begin
                  r_in = r_in - {1'b0, d_ff[s]};
                  q_in[0] = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         n_ff[s+1] <= n_in;
         q_ff[s+1] <= q_in;
         r_ff[s+1] <= r_in;
         d_ff[s+1] <= d_ff[s];
      end
   end
   assign quo = q_ff[DivRegs];
endmodule

[hdl/rbhp_axis.sv]
// per-axis coordinate check: product, sum, range test; two registers
module rbhp_axis
   import rbhp_pkg::*;
(
   input  logic      clock,
   input  coord_type t_val,
   input  coord_type dir,
   input  coord_type org,
   input  coord_type lo,
   input  coord_type hi,
   output logic      ok,
   output coord_type coord
);
   logic signed [2*CoordBits-1:0] prod_ff, prod_in;
   coord_type org_ff, lo_ff, hi_ff;
   logic      ok_ff, ok_in;
   coord_type c_ff, c_in;
   logic [2*CoordBits-1:0] pm;
   logic [2*CoordBits-FracBits-1:0] sh;
   coord_type pv;
   logic signed [CoordBits:0] sum;

   assign prod_in = t_val * dir;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      org_ff <= org;
      lo_ff <= lo;
      hi_ff <= hi;
   end
   always_comb begin
      pm = prod_ff[2*CoordBits-1] ? -prod_ff : prod_ff;
      sh = pm[2*CoordBits-1:FracBits];
      if (sh >= (2*CoordBits-FracBits)'(1) << (CoordBits - 1))
         pv = sat_word(prod_ff[2*CoordBits-1], NumBits'(1) << (CoordBits - 1));
      else
         pv = sat_word(prod_ff[2*CoordBits-1], NumBits'(sh));
      sum = {org_ff[CoordBits-1], org_ff} + {pv[CoordBits-1], pv};
      ok_in = !(sum < $signed({lo_ff[CoordBits-1], lo_ff}))
           && !(sum > $signed({hi_ff[CoordBits-1], hi_ff}));
      c_in = coord_type'(sum);
   end
   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      c_ff <= c_in;
   end
   assign ok = ok_ff;
   assign coord = c_ff;
endmodule

[hdl/ray_box_hit_point.sv]
// Woo ray/box hit point, signed Q16.16. One request is accepted every cycle
// (busy is always low); its response appears on rsp_valid after passing the
// bin stage, 13 divider stages, t select, two multiply/check stages and the
// output register. The deep divider sets the latency. The receiver cannot
// stall, so there is no backpressure.
module ray_box_hit_point
   import rbhp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  coord_type req_origin_x, req_origin_y, req_origin_z,
   input  coord_type req_direction_x, req_direction_y, req_direction_z,
   input  coord_type req_box_low_x, req_box_low_y, req_box_low_z,
   input  coord_type req_box_high_x, req_box_high_y, req_box_high_z,
   output logic      rsp_valid,
   output logic      rsp_hit,
   output logic      rsp_origin_inside,
   output coord_type rsp_hit_x, rsp_hit_y, rsp_hit_z
);
   assign busy = 1'b0;

   // stage 0: slab classification
   coord_type o[3], d[3], l[3], h[3];
   assign o = '{req_origin_x, req_origin_y, req_origin_z};
   assign d = '{req_direction_x, req_direction_y, req_direction_z};
   assign l = '{req_box_low_x, req_box_low_y, req_box_low_z};
   assign h = '{req_box_high_x, req_box_high_y, req_box_high_z};

   ray_type   r0_in, r0_ff;
   coord_type pl[3];
   logic [2:0] mid;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mid[i] = 1'b0;
         pl[i] = l[i];
         if (o[i] < l[i]) pl[i] = l[i];
         else if (o[i] > h[i]) pl[i] = h[i];
         else mid[i] = 1'b1;
      end
      r0_in.valid = start && !reset;
      r0_in.in_box = &mid;
      r0_in.org_x = o[0]; r0_in.org_y = o[1]; r0_in.org_z = o[2];
      r0_in.dir_x = d[0]; r0_in.dir_y = d[1]; r0_in.dir_z = d[2];
      r0_in.lo_x = l[0]; r0_in.lo_y = l[1]; r0_in.lo_z = l[2];
      r0_in.hi_x = h[0]; r0_in.hi_y = h[1]; r0_in.hi_z = h[2];
      r0_in.pl_x = pl[0]; r0_in.pl_y = pl[1]; r0_in.pl_z = pl[2];
      for (int i = 0; i < 3; i++) r0_in.use_t[i] = !mid[i] && (d[i] != '0);
   end
   always_ff @(posedge clock) begin
      if (reset) r0_ff.valid <= 1'b0;
      else r0_ff.valid <= r0_in.valid;
      r0_ff[$bits(ray_type)-2:0] <= r0_in[$bits(ray_type)-2:0];
   end

   // numerators and divider inputs
   coord_type r0o[3], r0d[3], r0p[3];
   assign r0o = '{r0_ff.org_x, r0_ff.org_y, r0_ff.org_z};
   assign r0d = '{r0_ff.dir_x, r0_ff.dir_y, r0_ff.dir_z};
   assign r0p = '{r0_ff.pl_x, r0_ff.pl_y, r0_ff.pl_z};
   mag_type  quo[3];
   logic [2:0] neg;
   for (genvar a = 0; a < 3; a++) begin : g_div
      logic signed [CoordBits:0] diff;
      logic [CoordBits:0] nm;
      dmag_type dm;
      assign diff = {r0p[a][CoordBits-1], r0p[a]} - {r0o[a][CoordBits-1], r0o[a]};
      assign nm = diff[CoordBits] ? -diff : diff;
      assign dm = r0d[a][CoordBits-1] ? -r0d[a] : r0d[a];
      assign neg[a] = diff[CoordBits] != r0d[a][CoordBits-1];
      rbhp_div u_div (
         .clock (clock),
         .num_in({nm, {FracBits{1'b0}}}),
         .den_in(dm == '0 ? dmag_type'(1) : dm),
         .quo   (quo[a])
      );
   end

   // side delay line alongside the divider
   ray_type    dl_ff [DivRegs+1];
   logic [2:0] ng_ff [DivRegs+1];
   always_comb begin
      dl_ff[0] = r0_ff;
      ng_ff[0] = neg;
   end
   for (genvar s = 0; s < DivRegs; s++) begin : g_dl
      always_ff @(posedge clock) begin
         if (reset) dl_ff[s+1].valid <= 1'b0;
         else dl_ff[s+1].valid <= dl_ff[s].valid;
         dl_ff[s+1][$bits(ray_type)-2:0] <= dl_ff[s][$bits(ray_type)-2:0];
         ng_ff[s+1] <= ng_ff[s];
      end
   end
   ray_type rd;
   assign rd = dl_ff[DivRegs];

   // select winning t
   coord_type t[3];
   always_comb
      for (int i = 0; i < 3; i++)
         t[i] = rd.use_t[i] ? sat_word(ng_ff[DivRegs][i], quo[i]) : MinusOne;
   logic [1:0] best;
   coord_type  tb;
   always_comb begin
      best = 2'd0; tb = t[0];
      if (tb < t[1]) begin best = 2'd1; tb = t[1]; end
      if (tb < t[2]) begin best = 2'd2; tb = t[2]; end
   end
   ray_type   s1_ff;
   coord_type t_ff;
   logic [1:0] best_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_ff.valid <= 1'b0;
      else s1_ff.valid <= rd.valid;
      s1_ff[$bits(ray_type)-2:0] <= rd[$bits(ray_type)-2:0];
      t_ff <= tb;
      best_ff <= best;
   end

   // multiply and check per axis, registered in rbhp_axis
   logic      ok[3];
   coord_type cc[3];
   coord_type so[3], sd[3], slo[3], shi[3];
   assign so = '{s1_ff.org_x, s1_ff.org_y, s1_ff.org_z};
   assign sd = '{s1_ff.dir_x, s1_ff.dir_y, s1_ff.dir_z};
   assign slo = '{s1_ff.lo_x, s1_ff.lo_y, s1_ff.lo_z};
   assign shi = '{s1_ff.hi_x, s1_ff.hi_y, s1_ff.hi_z};
   for (genvar a = 0; a < 3; a++) begin : g_ax
      rbhp_axis u_axis (
         .clock(clock), .t_val(t_ff), .dir(sd[a]), .org(so[a]),
         .lo(slo[a]), .hi(shi[a]), .ok(ok[a]), .coord(cc[a])
      );
   end
   ray_type    s2_ff [3];
   coord_type  t2_ff [3];
   logic [1:0] b2_ff [3];
   always_comb begin
      s2_ff[0] = s1_ff; t2_ff[0] = t_ff; b2_ff[0] = best_ff;
   end
   for (genvar s = 0; s < 2; s++) begin : g_s2
      always_ff @(posedge clock) begin
         if (reset) s2_ff[s+1].valid <= 1'b0;
         else s2_ff[s+1].valid <= s2_ff[s].valid;
         s2_ff[s+1][$bits(ray_type)-2:0] <= s2_ff[s][$bits(ray_type)-2:0];
         t2_ff[s+1] <= t2_ff[s];
         b2_ff[s+1] <= b2_ff[s];
      end
   end

   // final assembly
   ray_type   fr;
   coord_type fo[3], fp[3], pt_in[3];
   logic      hit_in;
   assign fr = s2_ff[2];
   assign fo = '{fr.org_x, fr.org_y, fr.org_z};
   assign fp = '{fr.pl_x, fr.pl_y, fr.pl_z};
   always_comb begin
      hit_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         pt_in[i] = fo[i];
         if (!fr.in_box) begin
            if (b2_ff[2] == 2'(i)) pt_in[i] = fp[i];
            else begin
               pt_in[i] = cc[i];
               if (!ok[i]) hit_in = 1'b0;
            end
         end
      end
      if (!fr.in_box && t2_ff[2][CoordBits-1]) hit_in = 1'b0;
      if (!hit_in) for (int i = 0; i < 3; i++) pt_in[i] = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= fr.valid;
      rsp_hit <= hit_in;
      rsp_origin_inside <= fr.in_box;
      rsp_hit_x <= pt_in[0];
      rsp_hit_y <= pt_in[1];
      rsp_hit_z <= pt_in[2];
   end
endmodule

[hdl/rbhp_checker.sv]
`include "ray_box_hit_point_assert.svh"
module rbhp_checker
   import rbhp_pkg::*;
(
   input logic clock, reset, busy, rsp_valid, rsp_hit, rsp_origin_inside,
   input coord_type rsp_hit_x, rsp_hit_y, rsp_hit_z
);
   `RBHP_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
   `RBHP_ASSERT_IMP(a_inside_hits, clock, reset, rsp_valid && rsp_origin_inside, rsp_hit)
   `RBHP_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0 && !rsp_origin_inside)
   `RBHP_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule

bind ray_box_hit_point rbhp_checker u_rbhp_checker (.*);
